FILE: design/potu_pkg.sv
package potu_pkg;

  localparam int unsigned ElapsedW = 16;
  localparam int unsigned WeekdayW = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned HoldMsW  = 26;
  localparam int unsigned CountW   = 27;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 8;

  localparam int unsigned EnableBit = 7;
  localparam logic [HoldMsW-1:0] MsPerSecond = HoldMsW'(1000);

  typedef enum logic [CfgIdxW-1:0] {
    CfgEnableMask = 3'd0,
    CfgHoldOn     = 3'd1,
    CfgHoldOff    = 3'd2,
    CfgPinAssign  = 3'd3,
    CfgDayGating  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LevelOff     = 2'd0,
    LevelOn      = 2'd1,
    LevelUnknown = 2'd3
  } level_e;

  typedef struct packed {
    logic [WeekdayW-1:0] weekday;
    logic [ElapsedW-1:0] elapsed_ms;
  } tick_t;

  typedef struct packed {
    logic timer_active;
    logic pin_level;
    logic pin_write;
  } result_t;

endpackage

FILE: design/periodic_on_off_timer_unit.sv
// Channel   Dir  Beat fields (low bit first)
// s_axis    in   tdata: elapsed_ms[15:0], weekday[18:16], zero pad to 24 bits
// m_axis    out  tdata: pin_write[0], pin_level[1], timer_active[2], zero pad to 8
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, one register per write
//
// One beat per cycle unless m_axis stalls; a tick passes the tick and result registers.
// The tick register feeds one pass of accumulate and compare into the result register.
// Hold times are scaled to milliseconds when written, so no multiply sits in the tick path.
// Reset drops both valid flags, zeroes the counter, starts in the hold-on phase and marks
// the last level unknown.
// A stalled m_axis holds the result; the tick register still takes one more beat.
module periodic_on_off_timer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // elapsed_ms, weekday
  input  logic [potu_pkg::InTdataW-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // pin_write, pin_level, timer_active
  output logic [potu_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  input  logic                            cfg_we_i,
  input  logic [potu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [potu_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [potu_pkg::MaskW-1:0]   mask_q;
  logic [potu_pkg::HoldMsW-1:0] hold_on_ms_q;
  logic [potu_pkg::HoldMsW-1:0] hold_off_ms_q;
  logic                         pin_assigned_q;
  logic                         day_gating_q;

  logic                         tick_valid_q;
  potu_pkg::tick_t              tick_q;
  logic                         res_valid_q;
  potu_pkg::result_t            res_q;

  logic [potu_pkg::CountW-1:0]  count_q, count_d;
  logic                         on_phase_q, on_phase_d;
  potu_pkg::level_e             last_level_q, last_level_d;

  logic                         advance;
  logic                         active;
  logic                         day_hit;
  logic [potu_pkg::CountW-1:0]  sum;
  logic [potu_pkg::HoldMsW-1:0] limit;
  logic                         drive;
  potu_pkg::level_e             target;
  logic                         wrote;
  potu_pkg::result_t            res_d;
  logic [potu_pkg::HoldMsW-1:0] cfg_ms;

  assign advance         = tick_valid_q && (!res_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !tick_valid_q || advance;
  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = {{(potu_pkg::OutTdataW - 3){1'b0}}, res_q};

  assign cfg_ms = {{(potu_pkg::HoldMsW - potu_pkg::HoldW){1'b0}}, cfg_data_i}
                  * potu_pkg::MsPerSecond;

  always_comb begin
    day_hit = 1'b0;
    if (tick_q.weekday != '0) begin
      day_hit = mask_q[tick_q.weekday - 3'd1];
    end
    active = mask_q[potu_pkg::EnableBit] && (!day_gating_q || day_hit);

    sum   = count_q + {{(potu_pkg::CountW - potu_pkg::ElapsedW){1'b0}}, tick_q.elapsed_ms};
    limit = on_phase_q ? hold_on_ms_q : hold_off_ms_q;

    count_d    = count_q;
    on_phase_d = on_phase_q;
    drive      = 1'b0;
    target     = potu_pkg::LevelOff;
    if (!active) begin
      drive   = 1'b1;
      count_d = '0;
    end else if (sum > {1'b0, limit}) begin
      drive      = 1'b1;
      target     = on_phase_q ? potu_pkg::LevelOff : potu_pkg::LevelOn;
      count_d    = '0;
      on_phase_d = !on_phase_q;
    end else begin
      count_d = sum;
    end

    wrote        = drive && pin_assigned_q && (last_level_q != target);
    last_level_d = wrote ? target : last_level_q;

    res_d.pin_write    = wrote;
    res_d.pin_level    = (last_level_d == potu_pkg::LevelOn);
    res_d.timer_active = active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q         <= '0;
      hold_on_ms_q   <= '0;
      hold_off_ms_q  <= '0;
      pin_assigned_q <= 1'b0;
      day_gating_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (potu_pkg::cfg_idx_e'(cfg_idx_i))
        potu_pkg::CfgEnableMask: mask_q         <= cfg_data_i[potu_pkg::MaskW-1:0];
        potu_pkg::CfgHoldOn:     hold_on_ms_q   <= cfg_ms;
        potu_pkg::CfgHoldOff:    hold_off_ms_q  <= cfg_ms;
        potu_pkg::CfgPinAssign:  pin_assigned_q <= cfg_data_i[0];
        potu_pkg::CfgDayGating:  day_gating_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      count_q      <= '0;
      on_phase_q   <= 1'b1;
      last_level_q <= potu_pkg::LevelUnknown;
    end else begin
      if (s_axis_tready_o) begin
        tick_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        res_valid_q  <= 1'b1;
        count_q      <= count_d;
        on_phase_q   <= on_phase_d;
        last_level_q <= last_level_d;
      end else if (m_axis_tready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      tick_q <= s_axis_tdata_i[potu_pkg::ElapsedW + potu_pkg::WeekdayW - 1:0];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: test/periodic_on_off_timer_unit_test.sv
`timescale 1ns / 1ps

module periodic_on_off_timer_unit_test;

  localparam int unsigned IdleLimit = 600;
  localparam int unsigned RandomTicks = 1200;
  localparam logic [potu_pkg::CfgIdxW-1:0] CfgFirstUnused = potu_pkg::CfgDayGating + 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [potu_pkg::InTdataW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [potu_pkg::OutTdataW-1:0] m_axis_tdata_o;
  logic cfg_we_i = 1'b0;
  logic [potu_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [potu_pkg::CfgDataW-1:0] cfg_data_i = '0;

  periodic_on_off_timer_unit dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // shadow registers
  logic [potu_pkg::MaskW-1:0] cfg_mask = '0;
  logic [potu_pkg::HoldW-1:0] cfg_hold_on = '0;
  logic [potu_pkg::HoldW-1:0] cfg_hold_off = '0;
  logic cfg_pin = 1'b0;
  logic cfg_gating = 1'b1;

  // timer state
  logic [potu_pkg::CountW-1:0] count_ms = '0;
  logic on_phase = 1'b1;
  potu_pkg::level_e last_lvl = potu_pkg::LevelUnknown;

  potu_pkg::tick_t ticks_to_send[$];
  potu_pkg::result_t timer_outputs_due[$];
  int pushed_ticks = 0;
  int results_checked = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string field, int got, int want);
    $display("beat %0d: %s is %0d, expected %0d", results_checked, field, got, want);
    mismatches++;
  endtask

  task automatic advance_timer(potu_pkg::tick_t t);
    potu_pkg::result_t r;
    logic [potu_pkg::HoldMsW-1:0] limit_ms;
    logic active;
    logic crossed;
    potu_pkg::level_e target;
    r = '0;
    crossed = 1'b0;
    target = potu_pkg::LevelOff;
    active = cfg_mask[potu_pkg::EnableBit];
    if (cfg_gating) begin
      active = active && (t.weekday != '0) && cfg_mask[t.weekday - 1];
    end
    if (!active) begin
      crossed = 1'b1;
      count_ms = '0;
    end else begin
      count_ms = count_ms + potu_pkg::CountW'(t.elapsed_ms);
      limit_ms = potu_pkg::HoldMsW'(on_phase ? cfg_hold_on : cfg_hold_off)
                 * potu_pkg::MsPerSecond;
      if (count_ms > potu_pkg::CountW'(limit_ms)) begin
        crossed = 1'b1;
        target = on_phase ? potu_pkg::LevelOff : potu_pkg::LevelOn;
        count_ms = '0;
        on_phase = ~on_phase;
      end
    end
    if (crossed && cfg_pin && last_lvl != target) begin
      last_lvl = target;
      r.pin_write = 1'b1;
    end
    r.pin_level = (last_lvl == potu_pkg::LevelOn);
    r.timer_active = active;
    timer_outputs_due.push_back(r);
  endtask

  task automatic write_reg(logic [potu_pkg::CfgIdxW-1:0] idx,
                           logic [potu_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      potu_pkg::CfgEnableMask: cfg_mask = val[potu_pkg::MaskW-1:0];
      potu_pkg::CfgHoldOn: cfg_hold_on = val[potu_pkg::HoldW-1:0];
      potu_pkg::CfgHoldOff: cfg_hold_off = val[potu_pkg::HoldW-1:0];
      potu_pkg::CfgPinAssign: cfg_pin = val[0];
      potu_pkg::CfgDayGating: cfg_gating = val[0];
      default: ;
    endcase
  endtask

  task automatic set_timer(logic [potu_pkg::MaskW-1:0] mask, logic [potu_pkg::HoldW-1:0] on_s,
                           logic [potu_pkg::HoldW-1:0] off_s, logic pin, logic gate);
    write_reg(potu_pkg::CfgEnableMask, potu_pkg::CfgDataW'(mask));
    write_reg(potu_pkg::CfgHoldOn, potu_pkg::CfgDataW'(on_s));
    write_reg(potu_pkg::CfgHoldOff, potu_pkg::CfgDataW'(off_s));
    write_reg(potu_pkg::CfgPinAssign, potu_pkg::CfgDataW'(pin));
    write_reg(potu_pkg::CfgDayGating, potu_pkg::CfgDataW'(gate));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CfgFirstUnused + potu_pkg::CfgIdxW'($urandom_range(0, 2)),
                potu_pkg::CfgDataW'($urandom));
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_tick(int ms, int day);
    potu_pkg::tick_t t;
    t.elapsed_ms = potu_pkg::ElapsedW'(ms);
    t.weekday = potu_pkg::WeekdayW'(day);
    ticks_to_send.push_back(t);
    pushed_ticks++;
  endtask

  task automatic settle();
    while (results_checked < pushed_ticks) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [potu_pkg::HoldW-1:0] pick_hold();
    case ($urandom_range(0, 9))
      0: pick_hold = '1;
      1: pick_hold = potu_pkg::HoldW'($urandom);
      default: pick_hold = potu_pkg::HoldW'($urandom_range(0, 3));
    endcase
  endfunction

  // tick driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        advance_timer(potu_pkg::tick_t'(s_axis_tdata_i[$bits(potu_pkg::tick_t)-1:0]));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (ticks_to_send.size() != 0) begin
          s_axis_tdata_i <= {{(potu_pkg::InTdataW - $bits(potu_pkg::tick_t)){1'b0}},
                             ticks_to_send.pop_front()};
          s_axis_tvalid_i <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            send_gap = $urandom_range(0, 17);
            if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(10, 60);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : watch_results
    potu_pkg::result_t seen;
    potu_pkg::result_t due;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen = potu_pkg::result_t'(m_axis_tdata_o[$bits(potu_pkg::result_t)-1:0]);
        if (timer_outputs_due.size() == 0) begin
          report_mismatch("unexpected beat", int'(seen), 0);
        end else begin
          due = timer_outputs_due.pop_front();
          if (seen.pin_write !== due.pin_write)
            report_mismatch("pin_write", seen.pin_write, due.pin_write);
          if (seen.pin_level !== due.pin_level)
            report_mismatch("pin_level", seen.pin_level, due.pin_level);
          if (seen.timer_active !== due.timer_active)
            report_mismatch("timer_active", seen.timer_active, due.timer_active);
          if (m_axis_tdata_o[potu_pkg::OutTdataW-1:$bits(potu_pkg::result_t)] !== '0)
            report_mismatch("padding", int'(m_axis_tdata_o), int'(seen));
          results_checked++;
        end
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          recv_stall = $urandom_range(0, 17);
          if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(10, 60);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
          || cfg_we_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int ms;
    int day;
    logic [potu_pkg::MaskW-1:0] mask;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset values
    queue_tick(65535, 1);
    queue_tick(0, 0);
    settle();

    // weekday zero, zero hold times
    set_timer(8'hFF, 16'd0, 16'd0, 1'b1, 1'b1);
    queue_tick(0, 0);
    queue_tick(0, 1);
    queue_tick(1, 7);
    queue_tick(65535, 4);
    queue_tick(0, 2);
    queue_tick(65535, 3);
    settle();

    // gating off, hold boundary at exactly the limit
    set_timer(8'h80, 16'd1, 16'hFFFF, 1'b1, 1'b0);
    queue_tick(999, 5);
    queue_tick(1, 6);
    queue_tick(1, 7);
    queue_tick(65535, 0);
    queue_tick(65535, 1);
    settle();

    // enable clear, no pin
    set_timer(8'h7F, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    queue_tick(65535, 1);
    queue_tick(123, 7);
    settle();

    // single weekday selected
    set_timer(8'h81, 16'd0, 16'd2, 1'b1, 1'b1);
    queue_tick(100, 1);
    queue_tick(100, 2);
    queue_tick(2001, 1);
    queue_tick(1, 1);
    queue_tick(2001, 1);
    queue_tick(0, 0);
    settle();

    while (pushed_ticks < RandomTicks + 25) begin
      case ($urandom_range(0, 5))
        0: mask = 8'h00;
        1: mask = 8'hFF;
        2, 3: mask = {1'b1, 7'($urandom)};
        4: mask = 8'h80;
        default: mask = potu_pkg::MaskW'($urandom);
      endcase
      set_timer(mask, pick_hold(), pick_hold(), $urandom_range(0, 5) != 0,
                1'($urandom_range(0, 1)));
      n = $urandom_range(10, 80);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0: ms = 0;
          1: ms = 65535;
          2, 3, 4: ms = $urandom_range(0, 2500);
          default: ms = $urandom_range(0, 65535);
        endcase
        day = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 7);
        queue_tick(ms, day);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
